// ===== src/mcsort_pkg.sv =====
package mcsort_pkg;

    localparam int ELEM_W       = 16;
    localparam int IDX_W        = 3;
    localparam int DIM_W        = 4;
    localparam int SUM_W        = 19;
    localparam int CFG_IDX_W    = 2;
    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

    // one accumulation request from the load side to the column sum lanes
    typedef struct packed {
        logic                     en;
        logic                     clear;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] val;
    } t_acc;

    // clamp a dimension register into 1..maxv and return it minus one
    function automatic logic [IDX_W-1:0] clamp_m1(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] c;
        if (v == '0) begin
            c = DIM_W'(1);
        end else if (v > maxv) begin
            c = maxv;
        end else begin
            c = v;
        end
        return IDX_W'(c - DIM_W'(1));
    endfunction

endpackage

// ===== src/mcsort_store.sv =====
module mcsort_store
    import mcsort_pkg::*;
#(
    parameter int ADDR_W = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic signed [ELEM_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [ADDR_W-1:0]        i_raddr,
    output logic signed [ELEM_W-1:0] o_rdata
);

    logic signed [ELEM_W-1:0] r_mem [2**ADDR_W];
    logic signed [ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mcsort_sorter.sv =====
module mcsort_sorter
    import mcsort_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_acc             i_acc,
    input  logic             i_start,
    input  logic [IDX_W-1:0] i_cols_m1,
    input  logic [IDX_W-1:0] i_ord_idx,
    output logic [IDX_W-1:0] o_ord_col,
    output logic             o_done
);

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic signed [SUM_W-1:0] r_sum [MAX_COLS];
    logic [IDX_W-1:0]        r_ord [MAX_COLS];
    logic                    r_busy;
    logic [IDX_W-1:0]        r_c;

    logic signed [SUM_W-1:0] w_cur;
    logic [MAX_COLS-1:0]     w_bef;
    logic [IDX_W-1:0]        w_rank;

    // sum lanes: each lane adds only the elements of its own column
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_COLS; j++) begin
            if (i_acc.en) begin
                if (i_acc.col == IDX_W'(j)) begin
                    r_sum[j] <= (i_acc.clear ? SUM_W'(0) : r_sum[j]) + SUM_W'(i_acc.val);
                end else if (i_acc.clear) begin
                    r_sum[j] <= '0;
                end
            end
        end
    end

    // rank of the current column: count columns that go before it
    always_comb begin
        w_cur = r_sum[r_c[COL_AW-1:0]];
        for (int j = 0; j < MAX_COLS; j++) begin
            w_bef[j] = (IDX_W'(j) <= i_cols_m1) && (IDX_W'(j) != r_c) &&
                       ((r_sum[j] < w_cur) ||
                        ((r_sum[j] == w_cur) && (IDX_W'(j) < r_c)));
        end
        w_rank = IDX_W'($countones(w_bef));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_c    <= '0;
            for (int j = 0; j < MAX_COLS; j++) begin
                r_ord[j] <= IDX_W'(j);
            end
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_c    <= '0;
        end else if (r_busy) begin
            r_ord[w_rank[COL_AW-1:0]] <= r_c;
            if (r_c == i_cols_m1) begin
                r_busy <= 1'b0;
            end else begin
                r_c <= r_c + IDX_W'(1);
            end
        end
    end

    assign o_ord_col = r_ord[i_ord_idx[COL_AW-1:0]];
    assign o_done    = r_busy && (r_c == i_cols_m1);

endmodule

// ===== src/matrix_column_sort_by_sum.sv =====
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid/o_in_stall   i_element_value
// output    out        o_out_valid/i_out_stall o_out_value, o_source_column, o_out_row,
//                                              o_out_column, o_last_of_matrix
// config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// Elements load at one beat per cycle into the matrix memory while the column sum
// lanes accumulate. The last element starts the ranking pass: one column per cycle,
// through the single rank comparator row. Emit then reads the matrix memory one
// element per cycle while the output is not stalled, through the read stage and then
// the output register. Reset is synchronous and active low; there is no clearing pass.
// Input stays stalled through sort and emit. A stall on the output holds the read stage,
// the output register and the emit; once the last read has issued the next matrix may
// load meanwhile.
module matrix_column_sort_by_sum
    import mcsort_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [ELEM_W-1:0] i_element_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [ELEM_W-1:0] o_out_value,
    output logic [IDX_W-1:0]         o_source_column,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_column,
    output logic                     o_last_of_matrix,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DIM_W-1:0]         i_cfg_data
);

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_AW + COL_AW;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SORT,
        S_EMIT
    } t_state;

    t_state                   r_state;
    logic [DIM_W-1:0]         r_row_count;
    logic [DIM_W-1:0]         r_col_count;
    logic [IDX_W-1:0]         r_lr;
    logic [IDX_W-1:0]         r_lc;
    logic [IDX_W-1:0]         r_er;
    logic [IDX_W-1:0]         r_ec;
    // read stage: memory data register plus its tag
    logic                     r_s1_valid;
    logic [IDX_W-1:0]         r_s1_src;
    logic [IDX_W-1:0]         r_s1_row;
    logic [IDX_W-1:0]         r_s1_col;
    logic                     r_s1_last;
    // output register
    logic                     r_out_valid;
    logic signed [ELEM_W-1:0] r_out_value;
    logic [IDX_W-1:0]         r_out_src;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic                     r_out_last;

    logic [IDX_W-1:0]         w_rows_m1;
    logic [IDX_W-1:0]         w_cols_m1;
    logic                     w_in_accept;
    logic                     w_in_last;
    logic                     w_s1_move;
    logic                     w_issue;
    logic                     w_emit_last;
    logic                     w_sort_done;
    logic [IDX_W-1:0]         w_ord_col;
    logic signed [ELEM_W-1:0] w_rdata;
    t_acc                     w_acc;

    assign w_rows_m1 = clamp_m1(r_row_count, DIM_W'(MAX_ROWS));
    assign w_cols_m1 = clamp_m1(r_col_count, DIM_W'(MAX_COLS));

    assign o_in_stall  = (r_state != S_LOAD);
    assign w_in_accept = i_in_valid && (r_state == S_LOAD);
    assign w_in_last   = (r_lr == w_rows_m1) && (r_lc == w_cols_m1);

    assign w_acc.en    = w_in_accept;
    assign w_acc.clear = (r_lr == '0) && (r_lc == '0);
    assign w_acc.col   = r_lc;
    assign w_acc.val   = i_element_value;

    // advance the read stage whenever the output register is free or being taken
    assign w_s1_move   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign w_issue     = (r_state == S_EMIT) && (!r_s1_valid || w_s1_move);
    assign w_emit_last = (r_er == w_rows_m1) && (r_ec == w_cols_m1);

    mcsort_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_accept),
        .i_waddr ({r_lr[ROW_AW-1:0], r_lc[COL_AW-1:0]}),
        .i_wdata (i_element_value),
        .i_re    (w_issue),
        .i_raddr ({r_er[ROW_AW-1:0], w_ord_col[COL_AW-1:0]}),
        .o_rdata (w_rdata)
    );

    mcsort_sorter #(
        .MAX_COLS (MAX_COLS)
    ) u_sorter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (w_acc),
        .i_start   (w_in_accept && w_in_last),
        .i_cols_m1 (w_cols_m1),
        .i_ord_idx (r_ec),
        .o_ord_col (w_ord_col),
        .o_done    (w_sort_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_row_count <= DIM_RESET;
            r_col_count <= DIM_RESET;
            r_lr        <= '0;
            r_lc        <= '0;
            r_er        <= '0;
            r_ec        <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_accept) begin
                        if (w_in_last) begin
                            r_lr    <= '0;
                            r_lc    <= '0;
                            r_state <= S_SORT;
                        end else if (r_lc == w_cols_m1) begin
                            r_lc <= '0;
                            r_lr <= r_lr + IDX_W'(1);
                        end else begin
                            r_lc <= r_lc + IDX_W'(1);
                        end
                    end
                end
                S_SORT: begin
                    if (w_sort_done) begin
                        r_er    <= '0;
                        r_ec    <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_issue) begin
                        if (w_emit_last) begin
                            r_state <= S_LOAD;
                        end else if (r_ec == w_cols_m1) begin
                            r_ec <= '0;
                            r_er <= r_er + IDX_W'(1);
                        end else begin
                            r_ec <= r_ec + IDX_W'(1);
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase

            // a register write drops any partly loaded matrix
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ROW_COUNT: begin
                        r_row_count <= i_cfg_data;
                        r_lr        <= '0;
                        r_lc        <= '0;
                    end
                    REG_COLUMN_COUNT: begin
                        r_col_count <= i_cfg_data;
                        r_lr        <= '0;
                        r_lc        <= '0;
                    end
                    default: ;
                endcase
            end

            if (w_issue) begin
                r_s1_valid <= 1'b1;
                r_s1_src   <= w_ord_col;
                r_s1_row   <= r_er;
                r_s1_col   <= r_ec;
                r_s1_last  <= w_emit_last;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_move) begin
                r_out_valid <= 1'b1;
                r_out_value <= w_rdata;
                r_out_src   <= r_s1_src;
                r_out_row   <= r_s1_row;
                r_out_col   <= r_s1_col;
                r_out_last  <= r_s1_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_value      = r_out_value;
    assign o_source_column  = r_out_src;
    assign o_out_row        = r_out_row;
    assign o_out_column     = r_out_col;
    assign o_last_of_matrix = r_out_last;

    a_load_to_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_in_last) |=> (r_state == S_SORT))
        else $error("last element did not start the ranking pass");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_matrix) |->
            ((o_out_row == w_rows_m1) && (o_out_column == w_cols_m1)))
        else $error("end of matrix flagged at wrong position");

    a_src_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_source_column <= w_cols_m1))
        else $error("source column outside the matrix");

endmodule
